### design/ftc_pkg.sv
// Package for the FIFO-replacement tag cache.
// Holds the sizes, field types, sequencer states and the control and status structs.
// It has no dependencies; every other file of the block imports it.
`default_nettype none

package ftc_pkg;

  localparam int SLOTS    = 8;
  localparam int TAG_BITS = 16;
  localparam int FIELD_W  = 16;
  localparam int POS_W    = 3;
  localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W    = $clog2(SLOTS + 1);

  typedef logic [TAG_BITS-1:0] tag_t;
  typedef logic [FIELD_W-1:0]  field_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } seq_state_e;

  typedef struct packed {
    logic load_req;
    logic insert;
  } store_ctrl_t;

  typedef struct packed {
    logic match;
    logic last;
    logic empty;
    logic full;
  } store_status_t;

  function automatic field_t tag_to_field(tag_t t);
    logic [FIELD_W+TAG_BITS-1:0] w;
    w = {{FIELD_W{1'b0}}, t};
    return w[FIELD_W-1:0];
  endfunction

  function automatic tag_t field_to_tag(field_t f);
    logic [FIELD_W+TAG_BITS-1:0] w;
    w = {{TAG_BITS{1'b0}}, f};
    return w[TAG_BITS-1:0];
  endfunction

  function automatic pos_t idx_to_pos(idx_t i);
    logic [POS_W+IDX_W-1:0] w;
    w = {{POS_W{1'b0}}, i};
    return w[POS_W-1:0];
  endfunction

endpackage

`default_nettype wire

### design/ftc_store.sv
// Tag store of the FIFO-replacement tag cache: ordered tag shift line, fill count,
// identifier counter, request registers and the shared tag comparator.
// Depends on ftc_pkg.
`default_nettype none

module ftc_store (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  ftc_pkg::store_ctrl_t   ctrl_i,
  input  wire                    op_i,
  input  ftc_pkg::field_t        tag_i,
  input  ftc_pkg::idx_t          idx_i,
  output ftc_pkg::store_status_t status_o,
  output ftc_pkg::tag_t          front_tag_o,
  output ftc_pkg::tag_t          ins_tag_o,
  output ftc_pkg::tag_t          last_tag_o
);
  import ftc_pkg::*;

  tag_t tags_q [SLOTS];
  cnt_t count_q, count_d;
  tag_t id_q, id_d;
  tag_t req_tag_q;
  logic req_push_q;

  assign ins_tag_o   = req_push_q ? id_q : req_tag_q;
  assign front_tag_o = tags_q[0];
  assign last_tag_o  = tags_q[SLOTS-1];

  assign status_o.match = (tags_q[idx_i] == req_tag_q);
  assign status_o.last  = (cnt_t'(idx_i) == (count_q - cnt_t'(1)));
  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == cnt_t'(SLOTS));

  always_comb begin
    count_d = count_q;
    id_d    = id_q;
    if (ctrl_i.insert) begin
      if (!status_o.full) begin
        count_d = count_q + cnt_t'(1);
      end
      if (req_push_q) begin
        id_d = id_q + tag_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      id_q    <= '0;
    end else begin
      count_q <= count_d;
      id_q    <= id_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_req) begin
      req_tag_q  <= field_to_tag(tag_i);
      req_push_q <= op_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.insert) begin
      tags_q[0] <= ins_tag_o;
      for (int n = 1; n < SLOTS; n++) begin
        tags_q[n] <= tags_q[n-1];
      end
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(SLOTS))
    else $error("fill count exceeds the number of slots");

  a_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.insert && !status_o.full) |=> (count_q == $past(count_q) + cnt_t'(1)))
    else $error("fill count did not grow on an insert into a free slot");

  a_id_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.insert && req_push_q) |=> (id_q == tag_t'($past(id_q) + tag_t'(1))))
    else $error("identifier did not advance on a push");
`endif

endmodule

`default_nettype wire

### design/ftc_seq.sv
// Sequencer of the FIFO-replacement tag cache: walks the comparator over the
// valid slots one per cycle on a lookup into a non-empty store, then finishes.
// Depends on ftc_pkg.
`default_nettype none

module ftc_seq (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  input  wire                    op_i,
  input  wire                    out_free_i,
  input  ftc_pkg::store_status_t status_i,
  output logic                   in_stall_o,
  output ftc_pkg::store_ctrl_t   ctrl_o,
  output ftc_pkg::idx_t          idx_o,
  output logic                   hit_o,
  output logic                   load_out_o
);
  import ftc_pkg::*;

  seq_state_e state_q, state_d;
  idx_t       idx_q, idx_d;
  logic       hit_q, hit_d;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    hit_d   = hit_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          idx_d   = '0;
          hit_d   = 1'b0;
          state_d = (op_i || status_i.empty) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.match) begin
          hit_d   = 1'b1;
          state_d = ST_FINISH;
        end else if (status_i.last) begin
          state_d = ST_FINISH;
        end else begin
          idx_d = idx_q + idx_t'(1);
        end
      end
      ST_FINISH: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_o      = (state_q != ST_IDLE);
    ctrl_o.load_req = (state_q == ST_IDLE) && in_valid_i;
    load_out_o      = (state_q == ST_FINISH) && out_free_i;
    ctrl_o.insert   = load_out_o && !hit_q;
  end

  assign idx_o = idx_q;
  assign hit_o = hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      hit_q   <= hit_d;
    end
  end

`ifndef SYNTHESIS
  a_scan_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !status_i.empty)
    else $error("scan started on an empty store");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != ST_IDLE))
    else $error("accepted transaction did not start the sequencer");

  a_match_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && status_i.match) |=> (state_q == ST_FINISH && hit_q))
    else $error("a match did not end the scan with a hit");
`endif

endmodule

`default_nettype wire

### design/fifo_replacement_tag_cache.sv
// A push, or a lookup on an empty store, skips the scan and goes straight to the finish state.
// A lookup on a non-empty store compares one slot per cycle on a single comparator and stops
// at the first matching slot or after the last valid slot.
// One transaction at a time; the next is accepted in the cycle after the result is registered.
// Reset clears the fill count, the identifier counter and the control state; tags are not reset.
`default_nettype none

module fifo_replacement_tag_cache (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_stall_o,
  input  wire              op_i,
  input  ftc_pkg::field_t  tag_i,
  output logic             out_valid_o,
  input  wire              out_stall_i,
  output logic             hit_o,
  output ftc_pkg::pos_t    hit_position_o,
  output logic             evict_o,
  output ftc_pkg::field_t  victim_tag_o,
  output ftc_pkg::field_t  front_tag_o
);
  import ftc_pkg::*;

  store_ctrl_t   ctrl;
  store_status_t status;
  idx_t          idx;
  logic          seq_hit;
  logic          load_out;
  logic          out_free;
  tag_t          store_front;
  tag_t          ins_tag;
  tag_t          last_tag;

  logic   out_valid_q, out_valid_d;
  logic   hit_q;
  pos_t   pos_q;
  logic   evict_q;
  field_t victim_q;
  field_t front_q;

  assign out_free = !out_valid_q || !out_stall_i;

  ftc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .out_free_i (out_free),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .ctrl_o     (ctrl),
    .idx_o      (idx),
    .hit_o      (seq_hit),
    .load_out_o (load_out)
  );

  ftc_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .op_i        (op_i),
    .tag_i       (tag_i),
    .idx_i       (idx),
    .status_o    (status),
    .front_tag_o (store_front),
    .ins_tag_o   (ins_tag),
    .last_tag_o  (last_tag)
  );

  assign out_valid_d = load_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      hit_q    <= seq_hit;
      pos_q    <= seq_hit ? idx_to_pos(idx) : '0;
      evict_q  <= !seq_hit && status.full;
      victim_q <= (!seq_hit && status.full) ? tag_to_field(last_tag) : '0;
      front_q  <= seq_hit ? tag_to_field(store_front) : tag_to_field(ins_tag);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_q;
  assign hit_position_o = pos_q;
  assign evict_o        = evict_q;
  assign victim_tag_o   = victim_q;
  assign front_tag_o    = front_q;

endmodule

`default_nettype wire
